/* src/spl_pkg.sv */
`default_nettype none
package spl_pkg;

  localparam int SEG_SLOTS      = 8;
  localparam int PAGES_PER_SEG  = 64;
  localparam int FIRST_PAGE     = 1;
  localparam int PAGE_BYTES_DEF = 65536;

  localparam int USABLE  = PAGES_PER_SEG - FIRST_PAGE;
  localparam int CAP_MAX = 131071;
  localparam int BS_W    = 17;
  localparam int CL_W    = 4;

  localparam int SLOT_W = $clog2(SEG_SLOTS);
  localparam int PAGE_W = $clog2(PAGES_PER_SEG);
  localparam int LINK_W = $clog2(SEG_SLOTS + 1);
  localparam int CNT_W  = $clog2(USABLE + 1);
  localparam int K_W    = $clog2(USABLE);
  localparam int ADDR_W = $clog2(SEG_SLOTS * PAGES_PER_SEG);
  localparam int TOT_W  = $clog2(SEG_SLOTS * USABLE + 1);
  localparam int MAPC_W = $clog2(SEG_SLOTS + 1);

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(SEG_SLOTS);

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_NOSEG,
    STAT_BADREL
  } spl_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_ACQ_RD,
    ST_ACQ_CMT,
    ST_DIV_WAIT,
    ST_REL_RD,
    ST_REL_CMT,
    ST_DONE
  } spl_state_t;

  typedef struct packed {
    logic        cmd;
    logic [16:0] blk_bytes;
    logic [7:0]  blk_class;
    logic [7:0]  owner_id;
    logic [2:0]  seg_slot;
    logic [5:0]  page_index;
  } spl_in_t;

  typedef struct packed {
    spl_status_t status;
    logic [2:0]  got_slot;
    logic [5:0]  got_page;
    logic [16:0] capacity;
    logic        unmapped;
    logic [3:0]  segments_mapped;
    logic [8:0]  pages_used;
    logic [8:0]  pages_free;
  } spl_out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic fail;
    logic map_begin;
    logic map_step;
    logic acq_read;
    logic acq_commit;
    logic rel_read;
    logic rel_commit;
    logic emit;
  } spl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic head_nil;
    logic all_mapped;
    logic map_last;
    logic div_busy;
  } spl_stat_t;

  function automatic logic [ADDR_W-1:0] seg_addr(input logic [SLOT_W-1:0] s,
                                                 input logic [PAGE_W-1:0] p);
    seg_addr = ADDR_W'(ADDR_W'(s) * ADDR_W'(PAGES_PER_SEG)) + ADDR_W'(p);
  endfunction

endpackage
`default_nettype wire

/* src/spl_div.sv */
`default_nettype none
module spl_div
  import spl_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [BS_W-1:0] divisor,
  output logic                 busy,
  output logic [BS_W-1:0]      quot
);

  localparam int DW = $clog2(PAGE_BYTES + 1);
  localparam int CW = $clog2(DW + 1);
  localparam logic [DW-1:0] DIVIDEND = DW'(PAGE_BYTES);

  logic [BS_W-1:0] rem_r, d_r;
  logic [DW-1:0]   n_r, q_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic [BS_W:0]   trial;
  logic            fits;
  logic [31:0]     q_ext;

  // restoring divide, one quotient bit per cycle
  assign trial = {rem_r, n_r[DW-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= (divisor == '0) ? BS_W'(1) : divisor;
      rem_r <= '0;
      n_r   <= DIVIDEND;
      q_r   <= '0;
    end else if (busy_r) begin
      n_r   <= {n_r[DW-2:0], 1'b0};
      rem_r <= fits ? BS_W'(trial - {1'b0, d_r}) : BS_W'(trial);
      q_r   <= {q_r[DW-2:0], fits};
    end
  end

  assign q_ext = 32'(q_r);
  assign quot  = (q_ext > 32'(CAP_MAX)) ? BS_W'(CAP_MAX) : BS_W'(q_ext);
  assign busy  = busy_r;

endmodule
`default_nettype wire

/* src/spl_ctrl.sv */
`default_nettype none
module spl_ctrl
  import spl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      in_release,
  input  wire spl_stat_t stat,
  output logic           busy,
  output spl_cmd_t       cmd
);

  spl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_release) begin
            state_nxt = ST_REL_RD;
          end else if (stat.head_nil) begin
            state_nxt = stat.all_mapped ? ST_DONE : ST_MAP;
          end else begin
            state_nxt = ST_ACQ_RD;
          end
        end
      end
      ST_MAP: begin
        if (stat.map_last) begin
          state_nxt = ST_ACQ_RD;
        end
      end
      ST_ACQ_RD:  state_nxt = ST_ACQ_CMT;
      ST_ACQ_CMT: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_REL_RD:  state_nxt = ST_REL_CMT;
      ST_REL_CMT: state_nxt = ST_DONE;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.accept     = (state_r == ST_IDLE) && start;
    cmd.fail       = cmd.accept && !in_release && stat.head_nil && stat.all_mapped;
    cmd.map_begin  = cmd.accept && !in_release && stat.head_nil && !stat.all_mapped;
    cmd.map_step   = state_r == ST_MAP;
    cmd.acq_read   = state_r == ST_ACQ_RD;
    cmd.acq_commit = state_r == ST_ACQ_CMT;
    cmd.rel_read   = state_r == ST_REL_RD;
    cmd.rel_commit = state_r == ST_REL_CMT;
    cmd.emit       = state_r == ST_DONE;
    busy           = state_r != ST_IDLE;
  end

endmodule
`default_nettype wire

/* src/spl_dp.sv */
`default_nettype none
module spl_dp
  import spl_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire spl_in_t         in_word,
  input  wire logic            cfg_valid,
  input  wire logic [CL_W-1:0] cfg_data,
  input  wire spl_cmd_t        cmd,
  output spl_stat_t            stat,
  output logic                 out_valid,
  output spl_out_t             out_word
);

  // segment table; counts and links read only at cur_r
  logic [SEG_SLOTS-1:0] mapped_r;
  logic [CNT_W-1:0]     cnt_r      [SEG_SLOTS];
  logic [LINK_W-1:0]    next_lnk_r [SEG_SLOTS];
  logic [LINK_W-1:0]    prev_lnk_r [SEG_SLOTS];
  logic [LINK_W-1:0]    next_lnk_nxt [SEG_SLOTS];
  logic [LINK_W-1:0]    prev_lnk_nxt [SEG_SLOTS];
  logic [LINK_W-1:0]    head_r, head_nxt;

  logic [MAPC_W-1:0] mapc_r, idle_r;
  logic [TOT_W-1:0]  free_r, used_r;
  logic [CL_W-1:0]   cache_lim_r;

  // item registers
  logic [BS_W-1:0]   bs_r;
  logic [PAGE_W-1:0] rel_page_r;
  logic              rel_inrange_r;
  logic [SLOT_W-1:0] cur_r, map_slot_r, low_free;
  logic [K_W-1:0]    k_r;
  spl_status_t       status_r;
  logic [SLOT_W-1:0] gslot_r;
  logic [PAGE_W-1:0] gpage_r;
  logic              unm_r, acq_ok_r;
  logic              out_valid_r;
  spl_out_t          out_r;

  // free stacks and busy flags
  logic [PAGE_W-1:0] stack_mem [SEG_SLOTS*PAGES_PER_SEG];
  logic              busy_mem  [SEG_SLOTS*PAGES_PER_SEG];
  logic [PAGE_W-1:0] pg_rd_r;
  logic              busy_rd_r;

  logic              stk_we, bsy_we, bsy_wd;
  logic [ADDR_W-1:0] stk_wa, stk_ra, bsy_wa, bsy_ra;
  logic [PAGE_W-1:0] stk_wd;

  logic [CNT_W-1:0]  cnt_cur, cnt_inc;
  logic              was_empty, full, do_unm, rel_ok, map_last;
  logic              push_en, unl_en;
  logic [SLOT_W-1:0] push_s, up_s, un_s;
  logic [LINK_W-1:0] up_p, up_n;
  logic [BS_W-1:0]   div_quot;
  logic              div_busy;

  spl_div #(.PAGE_BYTES(PAGE_BYTES)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.acq_read),
    .divisor (bs_r),
    .busy    (div_busy),
    .quot    (div_quot)
  );

  always_comb begin
    low_free = '0;
    for (int i = SEG_SLOTS - 1; i >= 0; i--) begin
      if (!mapped_r[i]) begin
        low_free = SLOT_W'(i);
      end
    end
  end

  assign map_last  = k_r == K_W'(USABLE - 1);
  assign cnt_cur   = cnt_r[cur_r];
  assign cnt_inc   = cnt_cur + CNT_W'(1);
  assign was_empty = cnt_cur == '0;
  assign full      = cnt_inc == CNT_W'(USABLE);
  assign do_unm    = full && ((int'(idle_r) + 1) > int'(cache_lim_r));
  assign rel_ok    = rel_inrange_r && mapped_r[cur_r] && busy_rd_r &&
                     (int'(rel_page_r) >= FIRST_PAGE) &&
                     (int'(rel_page_r) < PAGES_PER_SEG);

  always_comb begin
    stat.head_nil   = head_r == NIL_LINK;
    stat.all_mapped = &mapped_r;
    stat.map_last   = map_last;
    stat.div_busy   = div_busy;
  end

  // available list: at most one push or one unlink per cycle
  always_comb begin
    push_en = 1'b0;
    push_s  = cur_r;
    unl_en  = 1'b0;
    if (cmd.map_step && map_last) begin
      push_en = 1'b1;
      push_s  = map_slot_r;
    end
    if (cmd.acq_commit && cnt_cur == CNT_W'(1)) begin
      unl_en = 1'b1;
    end
    if (cmd.rel_commit && rel_ok) begin
      // empty and full at once: push then unlink cancel out
      push_en = was_empty && !do_unm;
      unl_en  = !was_empty && do_unm;
    end
  end

  always_comb begin
    next_lnk_nxt = next_lnk_r;
    prev_lnk_nxt = prev_lnk_r;
    head_nxt     = head_r;
    up_s         = cur_r;
    up_p         = prev_lnk_r[up_s];
    up_n         = next_lnk_r[up_s];
    un_s         = push_s;
    if (push_en) begin
      prev_lnk_nxt[un_s] = NIL_LINK;
      next_lnk_nxt[un_s] = head_r;
      if (head_r != NIL_LINK) begin
        prev_lnk_nxt[head_r[SLOT_W-1:0]] = LINK_W'(un_s);
      end
      head_nxt = LINK_W'(un_s);
    end
    if (unl_en) begin
      if (up_p != NIL_LINK) begin
        next_lnk_nxt[up_p[SLOT_W-1:0]] = up_n;
      end else begin
        head_nxt = up_n;
      end
      if (up_n != NIL_LINK) begin
        prev_lnk_nxt[up_n[SLOT_W-1:0]] = up_p;
      end
      prev_lnk_nxt[up_s] = NIL_LINK;
      next_lnk_nxt[up_s] = NIL_LINK;
    end
  end

  // memory port selection
  always_comb begin
    stk_we = 1'b0;
    stk_wa = seg_addr(cur_r, PAGE_W'(cnt_cur));
    stk_wd = rel_page_r;
    bsy_we = 1'b0;
    bsy_wa = seg_addr(cur_r, rel_page_r);
    bsy_wd = 1'b0;
    if (cmd.map_step) begin
      stk_we = 1'b1;
      stk_wa = seg_addr(map_slot_r, PAGE_W'(k_r));
      stk_wd = PAGE_W'(FIRST_PAGE) + PAGE_W'(k_r);
      bsy_we = 1'b1;
      bsy_wa = seg_addr(map_slot_r, PAGE_W'(FIRST_PAGE) + PAGE_W'(k_r));
    end else if (cmd.rel_commit && rel_ok) begin
      stk_we = 1'b1;
      bsy_we = 1'b1;
    end else if (cmd.acq_commit) begin
      bsy_we = 1'b1;
      bsy_wa = seg_addr(cur_r, pg_rd_r);
      bsy_wd = 1'b1;
    end
    stk_ra = seg_addr(cur_r, PAGE_W'(cnt_cur - CNT_W'(1)));
    bsy_ra = seg_addr(cur_r, rel_page_r);
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (cmd.acq_read) begin
      pg_rd_r <= stack_mem[stk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (bsy_we) begin
      busy_mem[bsy_wa] <= bsy_wd;
    end
    if (cmd.rel_read) begin
      busy_rd_r <= busy_mem[bsy_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapped_r    <= '0;
      head_r      <= NIL_LINK;
      mapc_r      <= '0;
      idle_r      <= '0;
      free_r      <= '0;
      used_r      <= '0;
      cache_lim_r <= CL_W'(1);
      out_valid_r <= 1'b0;
      for (int i = 0; i < SEG_SLOTS; i++) begin
        cnt_r[i]      <= '0;
        next_lnk_r[i] <= NIL_LINK;
        prev_lnk_r[i] <= NIL_LINK;
      end
    end else begin
      out_valid_r <= cmd.emit;
      next_lnk_r  <= next_lnk_nxt;
      prev_lnk_r  <= prev_lnk_nxt;
      head_r      <= head_nxt;
      if (cfg_valid) begin
        cache_lim_r <= cfg_data;
      end
      if (cmd.map_step && map_last) begin
        mapped_r[map_slot_r] <= 1'b1;
        cnt_r[map_slot_r]    <= CNT_W'(USABLE);
        free_r               <= free_r + TOT_W'(USABLE);
        mapc_r               <= mapc_r + MAPC_W'(1);
        idle_r               <= idle_r + MAPC_W'(1);
      end
      if (cmd.acq_commit) begin
        if (cnt_cur == CNT_W'(USABLE)) begin
          idle_r <= idle_r - MAPC_W'(1);
        end
        cnt_r[cur_r] <= cnt_cur - CNT_W'(1);
        free_r       <= free_r - TOT_W'(1);
        used_r       <= used_r + TOT_W'(1);
      end
      if (cmd.rel_commit && rel_ok) begin
        used_r <= used_r - TOT_W'(1);
        if (do_unm) begin
          mapped_r[cur_r] <= 1'b0;
          cnt_r[cur_r]    <= '0;
          mapc_r          <= mapc_r - MAPC_W'(1);
          free_r          <= free_r + TOT_W'(1) - TOT_W'(USABLE);
        end else begin
          cnt_r[cur_r] <= cnt_inc;
          free_r       <= free_r + TOT_W'(1);
          if (full) begin
            idle_r <= idle_r + MAPC_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bs_r          <= in_word.blk_bytes;
      rel_page_r    <= PAGE_W'(in_word.page_index);
      rel_inrange_r <= int'(in_word.seg_slot) < SEG_SLOTS;
      cur_r         <= in_word.cmd ? SLOT_W'(in_word.seg_slot) : head_r[SLOT_W-1:0];
      status_r      <= cmd.fail ? STAT_NOSEG : STAT_OK;
      unm_r         <= 1'b0;
      acq_ok_r      <= 1'b0;
      gslot_r       <= '0;
      gpage_r       <= '0;
    end
    if (cmd.map_begin) begin
      map_slot_r <= low_free;
      k_r        <= '0;
    end
    if (cmd.map_step) begin
      k_r <= k_r + K_W'(1);
      if (map_last) begin
        cur_r <= map_slot_r;
      end
    end
    if (cmd.acq_commit) begin
      gslot_r  <= cur_r;
      gpage_r  <= pg_rd_r;
      acq_ok_r <= 1'b1;
    end
    if (cmd.rel_commit) begin
      if (!rel_ok) begin
        status_r <= STAT_BADREL;
      end
      unm_r <= rel_ok && do_unm;
    end
    if (cmd.emit) begin
      out_r.status          <= status_r;
      out_r.got_slot        <= 3'(gslot_r);
      out_r.got_page        <= 6'(gpage_r);
      out_r.capacity        <= acq_ok_r ? div_quot : '0;
      out_r.unmapped        <= unm_r;
      out_r.segments_mapped <= 4'(mapc_r);
      out_r.pages_used      <= 9'(used_r);
      out_r.pages_free      <= 9'(free_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

/* src/segment_page_allocator.sv */
// Acquire from an available segment: start to strobe is set by the 17-step
//   restoring divider for capacity (one bit per cycle).
// Acquire that has to map a segment first fills its free stack.
// Release passes through read and commit states; a failed acquire goes straight to done.
// One word in flight; next start taken in the strobe cycle; receiver never stalls.
// Reset (rst_n low, synchronous): no segment mapped, lists empty, cache_limit 1.
`default_nettype none
module segment_page_allocator
  import spl_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  // command channel
  input  wire logic            start,
  output logic                 busy,
  input  wire spl_in_t         in_word,
  // result channel, one-cycle strobe, no back-pressure
  output logic                 out_valid,
  output spl_out_t             out_word,
  // cache_limit register
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [CL_W-1:0] cfg_data
);

  spl_cmd_t  cmd;
  spl_stat_t stat;

  // cache_limit writable only while no word is in flight
  assign cfg_ready = !busy;

  // sequencer: chooses map / acquire / release phases
  spl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_release (in_word.cmd),
    .stat       (stat),
    .busy       (busy),
    .cmd        (cmd)
  );

  // segment table, free stacks, busy flags, divider, result register
  spl_dp #(.PAGE_BYTES(PAGE_BYTES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // a word taken always leaves idle on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // one strobe per word: never two results back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // out of segments only when every slot is mapped
  a_noseg_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == STAT_NOSEG) |->
      (int'(out_word.segments_mapped) == SEG_SLOTS))
    else $error("no-segment status with a free slot");

  // free pages bounded by mapped capacity
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_word.pages_free) <= int'(out_word.segments_mapped) * USABLE))
    else $error("free page count exceeds mapped capacity");

endmodule
`default_nettype wire
